@@ rtl/watchdog_timer_magic_close_macros.svh @@
// Assertion macros used by the watchdog engine module.
`ifndef WATCHDOG_TIMER_MAGIC_CLOSE_MACROS_SVH
`define WATCHDOG_TIMER_MAGIC_CLOSE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define WDMC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("watchdog same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define WDMC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("watchdog next-cycle check failed");

`endif

@@ rtl/wdmc_pkg.sv @@
// Types, codes and constants of the watchdog timer with magic close.
package wdmc_pkg;

    localparam int TICKS_PER_SECOND_DEF = 100;
    localparam int DEFAULT_TIMEOUT_DEF  = 60;
    localparam int COUNT_W              = 23;
    localparam int TIMEOUT_W            = 16;
    localparam int CFG_INDEX_W          = 8;
    localparam int CFG_DATA_W           = 8;
    localparam logic [7:0] MAGIC_BYTE   = 8'h56;

    typedef enum logic [2:0] {
        OP_TICK        = 3'd0,
        OP_OPEN        = 3'd1,
        OP_RELEASE     = 3'd2,
        OP_WRITE_BYTE  = 3'd3,
        OP_KEEPALIVE   = 3'd4,
        OP_SET_TIMEOUT = 3'd5,
        OP_GET_TIMEOUT = 3'd6,
        OP_GET_STATUS  = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BUSY        = 2'd1,
        ST_BAD_TIMEOUT = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NO_WAY_OUT = 8'd0,
        REG_NO_REBOOT  = 8'd1
    } reg_index_t;

    typedef struct packed {
        op_t                  op;
        logic [7:0]           data_byte;
        logic                 first_of_write;
        logic [TIMEOUT_W-1:0] new_timeout;
    } in_item_t;

    typedef struct packed {
        status_t              status;
        logic [TIMEOUT_W-1:0] read_value;
        logic                 fired;
        logic                 reboot_request;
        logic                 unexpected_close;
    } out_item_t;

    typedef struct packed {
        logic no_way_out;
        logic no_reboot;
    } cfg_t;

endpackage

@@ rtl/wdmc_cfg.sv @@
// Configuration registers written over the configuration channel.
module wdmc_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [wdmc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wdmc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output wdmc_pkg::cfg_t                  cfg
);
    import wdmc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_NO_WAY_OUT: cfg_next.no_way_out = cfg_data[0];
                REG_NO_REBOOT:  cfg_next.no_reboot  = cfg_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/wdmc_engine.sv @@
// Watchdog state registers and the single-pass logic that serves one item.
module wdmc_engine #(
    parameter int TICKS_PER_SECOND = wdmc_pkg::TICKS_PER_SECOND_DEF,
    parameter int DEFAULT_TIMEOUT  = wdmc_pkg::DEFAULT_TIMEOUT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  wdmc_pkg::in_item_t  item,
    input  wdmc_pkg::cfg_t      cfg,
    output wdmc_pkg::out_item_t result
);
    import wdmc_pkg::*;
    `include "watchdog_timer_magic_close_macros.svh"

    localparam int PROD_W = TIMEOUT_W + $clog2(TICKS_PER_SECOND + 1);

    logic [TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic [COUNT_W-1:0]   countdown_reg, countdown_next;
    logic                 armed_reg, armed_next;
    logic                 held_open_reg, held_open_next;
    logic                 close_allowed_reg, close_allowed_next;

    logic [TIMEOUT_W-1:0] reload_src;
    logic [PROD_W-1:0]    reload_prod;
    logic [COUNT_W-1:0]   reload_count;

    assign reload_src   = (item.op == OP_SET_TIMEOUT) ? item.new_timeout : timeout_reg;
    assign reload_prod  = PROD_W'(reload_src) * PROD_W'(TICKS_PER_SECOND);
    assign reload_count = COUNT_W'(reload_prod);

    always_comb begin
        timeout_next       = timeout_reg;
        countdown_next     = countdown_reg;
        armed_next         = armed_reg;
        held_open_next     = held_open_reg;
        close_allowed_next = close_allowed_reg;
        result             = '0;
        result.status      = ST_OK;
        case (item.op)
            OP_TICK: begin
                if (armed_reg) begin
                    if (countdown_reg <= COUNT_W'(1)) begin
                        countdown_next        = '0;
                        armed_next            = 1'b0;
                        result.fired          = 1'b1;
                        result.reboot_request = !cfg.no_reboot;
                    end else begin
                        countdown_next = countdown_reg - COUNT_W'(1);
                    end
                end
            end
            OP_OPEN: begin
                if (held_open_reg) begin
                    result.status = ST_BUSY;
                end else begin
                    held_open_next = 1'b1;
                    countdown_next = reload_count;
                    armed_next     = 1'b1;
                end
            end
            OP_RELEASE: begin
                if (close_allowed_reg || !cfg.no_way_out) begin
                    armed_next     = 1'b0;
                    countdown_next = '0;
                end else begin
                    result.unexpected_close = 1'b1;
                end
                held_open_next = 1'b0;
            end
            OP_WRITE_BYTE: begin
                if (!cfg.no_way_out) begin
                    if (item.data_byte == MAGIC_BYTE) begin
                        close_allowed_next = 1'b1;
                    end else if (item.first_of_write) begin
                        close_allowed_next = 1'b0;
                    end
                end
                countdown_next = reload_count;
                armed_next     = 1'b1;
            end
            OP_KEEPALIVE: begin
                countdown_next = reload_count;
                armed_next     = 1'b1;
            end
            OP_SET_TIMEOUT: begin
                if (item.new_timeout == '0) begin
                    result.status = ST_BAD_TIMEOUT;
                end else begin
                    timeout_next      = item.new_timeout;
                    countdown_next    = reload_count;
                    armed_next        = 1'b1;
                    result.read_value = item.new_timeout;
                end
            end
            OP_GET_TIMEOUT: begin
                result.read_value = timeout_reg;
            end
            default: begin
                result.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg       <= TIMEOUT_W'(DEFAULT_TIMEOUT);
            countdown_reg     <= '0;
            armed_reg         <= 1'b0;
            held_open_reg     <= 1'b0;
            close_allowed_reg <= 1'b0;
        end else if (fire) begin
            timeout_reg       <= timeout_next;
            countdown_reg     <= countdown_next;
            armed_reg         <= armed_next;
            held_open_reg     <= held_open_next;
            close_allowed_reg <= close_allowed_next;
        end
    end

    `WDMC_ASSERT_NEXT(a_fire_disarms, aclk, aresetn, fire && result.fired, !armed_reg)
    `WDMC_ASSERT_SAME(a_fire_on_tick, aclk, aresetn, result.fired, item.op == OP_TICK && armed_reg)
    `WDMC_ASSERT_SAME(a_reboot_needs_fire, aclk, aresetn, result.reboot_request, result.fired)
    `WDMC_ASSERT_SAME(a_disarmed_zero, aclk, aresetn, !armed_reg, countdown_reg == '0)
    `WDMC_ASSERT_NEXT(a_open_holds, aclk, aresetn, fire && item.op == OP_OPEN, held_open_reg)

endmodule

@@ rtl/wdmc_out_stage.sv @@
// Result register that holds a finished item until the consumer takes it.
module wdmc_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  wdmc_pkg::out_item_t load_data,
    output logic                can_load,
    output logic                m_valid,
    input  logic                m_ready,
    output wdmc_pkg::out_item_t m_data
);
    import wdmc_pkg::*;

    logic      out_valid_reg;
    out_item_t out_data_reg;

    assign can_load = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg <= load_data;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

@@ rtl/watchdog_timer_magic_close.sv @@
// Top level of the watchdog timer with magic close.
//
//   Channel   Direction  Handshake             Payload
//   s_        in         s_valid / s_ready     in_item_t: op, byte, first flag, timeout
//   m_        out        m_valid / m_ready     out_item_t: status, value, flags
//   cfg_      in         cfg_valid / cfg_ready index, data (bit 0 used)
//
// Every item gives one result: it waits in the input register, then passes through the
// engine logic into the result register.
// One item is taken per cycle unless the result stage stalls; the state update path holds
// one 16-bit by tick-rate multiply for the reload count.
// Synchronous active-low reset clears control and watchdog state and loads DEFAULT_TIMEOUT.
// A stalled result holds the engine, and s_ready drops once the input register is also full.
module watchdog_timer_magic_close #(
    parameter int TICKS_PER_SECOND = wdmc_pkg::TICKS_PER_SECOND_DEF,
    parameter int DEFAULT_TIMEOUT  = wdmc_pkg::DEFAULT_TIMEOUT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  wdmc_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output wdmc_pkg::out_item_t              m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wdmc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wdmc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import wdmc_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      can_load;
    logic      fire;
    cfg_t      cfg;
    out_item_t result;

    assign fire      = in_valid_reg && can_load;
    assign s_ready   = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    wdmc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wdmc_engine #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .DEFAULT_TIMEOUT  (DEFAULT_TIMEOUT)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    wdmc_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fire),
        .load_data (result),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
